FILE: rtl/assert_macros.svh
// Assertion helpers used by the queue datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property every clock, skipped while reset is high
`define DEQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deque assertion failed");

// Check a property every clock, reset included
`define DEQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("deque assertion failed");

`else

`define DEQ_ASSERT(label, clk, rst, prop)
`define DEQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/deq_pkg.sv
package deq_pkg;

   // Ring geometry
   localparam int CAPACITY = 16;
   localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = PTR_W + 1;
   localparam int DATA_W   = 32;

   typedef logic [PTR_W-1:0]         ptr_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [SUM_W-1:0]         sum_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [2:0]               kind_type;
   typedef logic [2:0]               status_type;

   // Request kinds
   localparam kind_type KIND_PUSH_FRONT = 3'd0;
   localparam kind_type KIND_PUSH_REAR  = 3'd1;
   localparam kind_type KIND_POP_FRONT  = 3'd2;
   localparam kind_type KIND_POP_REAR   = 3'd3;
   localparam kind_type KIND_LIST       = 3'd4;

   // Response status codes
   localparam status_type ST_DONE      = 3'd0;
   localparam status_type ST_UNDERFLOW = 3'd1;
   localparam status_type ST_OVERFLOW  = 3'd2;
   localparam status_type ST_IGNORED   = 3'd3;
   localparam status_type ST_ELEMENT   = 3'd4;
   localparam status_type ST_EMPTY     = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LIST_RD,
      S_LIST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;       // capture the accepted request
      logic exec;        // apply a single-result request and load its response
      logic list_start;  // clear the walk index
      logic list_read;   // read the slot under the walk index
      logic list_emit;   // load a listed element and advance the walk
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic halted;
      logic is_list;
      logic empty;
      logic out_free;
      logic walk_last;
   } dp_status_type;

   // Ring position of a + b, both below CAPACITY
   function automatic ptr_type ring_add(ptr_type a, ptr_type b);
      sum_type s;
      s = sum_type'(a) + sum_type'(b);
      if (s >= sum_type'(CAPACITY)) begin
         s = s - sum_type'(CAPACITY);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

FILE: rtl/deq_req_if.sv
interface deq_req_if;
   logic                valid;
   logic                ready;
   deq_pkg::kind_type   kind;
   deq_pkg::data_type   value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: rtl/deq_rsp_if.sv
interface deq_rsp_if;
   logic                 valid;
   logic                 ready;
   deq_pkg::status_type  status;
   deq_pkg::data_type    element;
   logic                 last;

   modport source (output valid, output status, output element, output last, input ready);
   modport sink   (input valid, input status, input element, input last, output ready);
endinterface

FILE: rtl/deq_ctrl.sv
module deq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  deq_pkg::dp_status_type dp_status,
   output deq_pkg::ctrl_cmd_type  ctrl_cmd
);

   deq_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      ctrl_cmd  = '0;
      req_ready = 1'b0;
      case (state_ff)
         deq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.latch = 1'b1;
               state_in       = deq_pkg::S_EXEC;
            end
         end
         deq_pkg::S_EXEC: begin
            if (dp_status.out_free) begin
               if (!dp_status.halted && dp_status.is_list && !dp_status.empty) begin
                  ctrl_cmd.list_start = 1'b1;
                  state_in            = deq_pkg::S_LIST_RD;
               end else begin
                  ctrl_cmd.exec = 1'b1;
                  state_in      = deq_pkg::S_IDLE;
               end
            end
         end
         deq_pkg::S_LIST_RD: begin
            ctrl_cmd.list_read = 1'b1;
            state_in           = deq_pkg::S_LIST_EMIT;
         end
         deq_pkg::S_LIST_EMIT: begin
            if (dp_status.out_free) begin
               ctrl_cmd.list_emit = 1'b1;
               state_in = dp_status.walk_last ? deq_pkg::S_IDLE : deq_pkg::S_LIST_RD;
            end
         end
         default: begin
            state_in = deq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/deq_dp.sv
`include "assert_macros.svh"

module deq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::kind_type      req_kind,
   input  deq_pkg::data_type      req_value,
   input  deq_pkg::ctrl_cmd_type  ctrl_cmd,
   output deq_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output deq_pkg::status_type    rsp_status,
   output deq_pkg::data_type      rsp_element,
   output logic                   rsp_last
);

   // Element storage, contents undefined until written
   deq_pkg::data_type   slots_ff [deq_pkg::CAPACITY];
   deq_pkg::data_type   rd_data_ff;

   deq_pkg::kind_type   kind_ff;
   deq_pkg::data_type   value_ff;
   deq_pkg::ptr_type    head_ff, head_in;
   deq_pkg::cnt_type    fill_ff, fill_in;
   logic                halted_ff, halted_in;
   deq_pkg::ptr_type    walk_ff;

   logic                valid_ff, valid_in;
   deq_pkg::status_type status_ff, status_in;
   deq_pkg::data_type   element_ff, element_in;
   logic                last_ff, last_in;

   logic                full, empty, out_free, walk_last, load;
   logic                wr_en;
   deq_pkg::ptr_type    wr_addr, head_dec, head_inc;

   assign full      = (fill_ff == deq_pkg::cnt_type'(deq_pkg::CAPACITY));
   assign empty     = (fill_ff == '0);
   assign out_free  = !valid_ff || rsp_ready;
   assign walk_last = ((deq_pkg::cnt_type'(walk_ff) + deq_pkg::cnt_type'(1)) == fill_ff);
   assign load      = ctrl_cmd.exec || ctrl_cmd.list_emit;

   assign head_dec = (head_ff == '0) ? deq_pkg::ptr_type'(deq_pkg::CAPACITY - 1)
                                     : head_ff - deq_pkg::ptr_type'(1);
   assign head_inc = (head_ff == deq_pkg::ptr_type'(deq_pkg::CAPACITY - 1))
                     ? '0 : head_ff + deq_pkg::ptr_type'(1);

   // Latch the accepted request
   always_ff @(posedge clock) begin
      if (ctrl_cmd.latch) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
   end

   // Apply single-result requests and build their response
   always_comb begin
      head_in    = head_ff;
      fill_in    = fill_ff;
      halted_in  = halted_ff;
      wr_en      = 1'b0;
      wr_addr    = head_dec;
      status_in  = deq_pkg::ST_DONE;
      element_in = '0;
      last_in    = 1'b1;
      if (ctrl_cmd.list_emit) begin
         status_in  = deq_pkg::ST_ELEMENT;
         element_in = rd_data_ff;
         last_in    = walk_last;
      end else if (halted_ff) begin
         status_in = deq_pkg::ST_IGNORED;
      end else begin
         case (kind_ff)
            deq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = deq_pkg::ST_OVERFLOW;
               end else begin
                  wr_en   = ctrl_cmd.exec;
                  wr_addr = head_dec;
                  head_in = head_dec;
                  fill_in = fill_ff + deq_pkg::cnt_type'(1);
               end
            end
            deq_pkg::KIND_PUSH_REAR: begin
               if (full) begin
                  status_in = deq_pkg::ST_OVERFLOW;
               end else begin
                  wr_en   = ctrl_cmd.exec;
                  wr_addr = deq_pkg::ring_add(head_ff, fill_ff[deq_pkg::PTR_W-1:0]);
                  fill_in = fill_ff + deq_pkg::cnt_type'(1);
               end
            end
            deq_pkg::KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = deq_pkg::ST_UNDERFLOW;
                  halted_in = 1'b1;
               end else begin
                  head_in = head_inc;
                  fill_in = fill_ff - deq_pkg::cnt_type'(1);
               end
            end
            deq_pkg::KIND_POP_REAR: begin
               if (empty) begin
                  status_in = deq_pkg::ST_UNDERFLOW;
                  halted_in = 1'b1;
               end else begin
                  fill_in = fill_ff - deq_pkg::cnt_type'(1);
               end
            end
            deq_pkg::KIND_LIST: begin
               status_in = deq_pkg::ST_EMPTY;
            end
            default: begin
               status_in = deq_pkg::ST_DONE;
            end
         endcase
      end
   end

   // Ring state, updated only when a request executes
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         fill_ff   <= '0;
         halted_ff <= 1'b0;
      end else if (ctrl_cmd.exec) begin
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         halted_ff <= halted_in;
      end
   end

   // Walk index for listings
   always_ff @(posedge clock) begin
      if (ctrl_cmd.list_start) begin
         walk_ff <= '0;
      end else if (ctrl_cmd.list_emit) begin
         walk_ff <= walk_ff + deq_pkg::ptr_type'(1);
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.list_read) begin
         rd_data_ff <= slots_ff[deq_pkg::ring_add(head_ff, walk_ff)];
      end
   end

   // Response register: load a new response, drop it once taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status_in;
         element_ff <= element_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_element = element_ff;
   assign rsp_last    = last_ff;

   assign dp_status.halted    = halted_ff;
   assign dp_status.is_list   = (kind_ff == deq_pkg::KIND_LIST);
   assign dp_status.empty     = empty;
   assign dp_status.out_free  = out_free;
   assign dp_status.walk_last = walk_last;

   `DEQ_ASSERT(a_fill_in_range, clock, reset, fill_ff <= deq_pkg::cnt_type'(deq_pkg::CAPACITY))
   `DEQ_ASSERT(a_halt_sticks, clock, reset, halted_ff |=> halted_ff)
   `DEQ_ASSERT(a_no_overwrite, clock, reset, (valid_ff && !rsp_ready) |-> !load)
   `DEQ_ASSERT(a_halted_ignores, clock, reset, (ctrl_cmd.exec && halted_ff) |=> (status_ff == deq_pkg::ST_IGNORED))

endmodule

FILE: rtl/double_ended_queue_top.sv
// Channel  Port      Direction  Payload
// request  req_chan  in         kind, value
// response rsp_chan  out        status, element, last
//
// A push, pop or halted request is accepted, then executed into the response register.
// A listing is accepted and then started; each stored element is then read from the single slot
// memory into a read register and afterwards loaded into the response register.
// Reset is synchronous; it clears the ring pointers, the halt flag, the response valid flag and the control state only.
// Slot contents are not cleared. A new request is taken while a response waits to be collected;
// execution holds until the response register is free.
module double_ended_queue_top (
   input logic clock,
   input logic reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   deq_pkg::ctrl_cmd_type  ctrl_cmd;
   deq_pkg::dp_status_type dp_status;
   logic                   req_ready;

   assign req_chan.ready = req_ready;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   deq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_kind    (req_chan.kind),
      .req_value   (req_chan.value),
      .ctrl_cmd    (ctrl_cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_status  (rsp_chan.status),
      .rsp_element (rsp_chan.element),
      .rsp_last    (rsp_chan.last)
   );

endmodule
